// ===== rtl/core/s1ie_pkg.sv =====
`default_nettype none
package s1ie_pkg;
  localparam int unsigned MaxTaItems = 16;
  localparam logic [15:0] IeGlobal = 16'd59;
  localparam logic [15:0] IeName = 16'd60;
  localparam logic [15:0] IeTas = 16'd64;
  localparam logic [7:0] ExtMark = 8'd8;

  typedef enum logic [2:0] {
    KIND_GLOBAL = 3'd0,
    KIND_NAME = 3'd1,
    KIND_TAC = 3'd2,
    KIND_PLMN = 3'd3,
    KIND_END = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_LENGTH = 3'd1,
    ST_CRIT = 3'd2,
    ST_TOO_MANY = 3'd3,
    ST_EXTENDED = 3'd4,
    ST_TRUNCATED = 3'd5
  } status_t;

  typedef enum logic [19:0] {
    PH_LEN = 20'h00001,
    PH_EXT = 20'h00002,
    PH_CNT_HI = 20'h00004,
    PH_CNT_LO = 20'h00008,
    PH_ID_HI = 20'h00010,
    PH_ID_LO = 20'h00020,
    PH_CRIT = 20'h00040,
    PH_IELEN = 20'h00080,
    PH_DONE = 20'h00100,
    PH_SKIP = 20'h00200,
    G_HDR = 20'h00400,
    G_PLMN = 20'h00800,
    G_TYPE = 20'h01000,
    G_ID = 20'h02000,
    N_HDR0 = 20'h04000,
    N_HDR1 = 20'h08000,
    N_CHARS = 20'h10000,
    T_COUNT = 20'h20000,
    T_ITEM = 20'h40000,
    T_PLMN = 20'h80000
  } phase_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [11:0] mcc_digits;
    logic [11:0] mnc_digits;
    logic home_enb;
    logic [27:0] enb_ident;
    logic [7:0] name_char;
    logic [15:0] tracking_code;
    logic [3:0] ta_index;
    logic [2:0] plmn_index;
    logic [2:0] status;
    logic last_result;
  } result_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic last_byte;
  } item_t;

  function automatic logic [11:0] mcc_of(input logic [23:0] acc);
    return {acc[19:16], acc[23:20], acc[11:8]};
  endfunction

  function automatic logic [11:0] mnc_of(input logic [23:0] acc);
    return {acc[3:0], acc[7:4], acc[15:12]};
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/s1ie_item_if.sv =====
`default_nettype none
interface s1ie_item_if import s1ie_pkg::*; ;
  logic valid;
  logic ready;
  item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/s1ie_result_if.sv =====
`default_nettype none
interface s1ie_result_if import s1ie_pkg::*; ;
  logic valid;
  logic ready;
  result_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/s1ie_decoder.sv =====
`default_nettype none
// parse state machine: one byte in, up to two results out, all combinational
module s1ie_decoder import s1ie_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic step,
  input wire logic [7:0] b,
  input wire logic last,
  output logic n0_valid,
  output result_t r0,
  output logic n1_valid,
  output result_t r1
);
  phase_t phase, phase_next;
  logic [3:0] header_pos, header_pos_next;
  logic [15:0] ies_left, ies_left_next;
  logic [15:0] ie_ident, ie_ident_next;
  logic [7:0] ie_bytes_left, ie_bytes_left_next;
  logic [15:0] length_sum, length_sum_next;
  logic [7:0] message_length, message_length_next;
  logic [31:0] shift_acc, shift_acc_next;
  logic [8:0] name_left, name_left_next;
  logic [4:0] tas_left, tas_left_next;
  logic [2:0] plmns_left, plmns_left_next;
  logic [3:0] ta_count, ta_count_next;
  logic [2:0] plmn_count, plmn_count_next;
  logic [2:0] error_code, error_code_next;
  logic home_flag, home_flag_next;
  logic [23:0] plmn_hold, plmn_hold_next;
  logic [31:0] shifted;
  logic [15:0] ies_dec;
  logic [7:0] bytes_dec;
  logic [3:0] pos_inc;
  logic [4:0] tas_dec;
  logic [8:0] count_plus;
  logic [2:0] st;

  always_comb begin
    shifted = {shift_acc[23:0], b};
    pos_inc = header_pos + 4'd1;
    bytes_dec = ie_bytes_left - 8'd1;
    ies_dec = ies_left - 16'd1;
    tas_dec = tas_left - 5'd1;
    count_plus = {1'b0, b} + 9'd1;
    phase_next = phase;
    header_pos_next = header_pos;
    ies_left_next = ies_left;
    ie_ident_next = ie_ident;
    ie_bytes_left_next = ie_bytes_left;
    length_sum_next = length_sum;
    message_length_next = message_length;
    shift_acc_next = shift_acc;
    name_left_next = name_left;
    tas_left_next = tas_left;
    plmns_left_next = plmns_left;
    ta_count_next = ta_count;
    plmn_count_next = plmn_count;
    error_code_next = error_code;
    home_flag_next = home_flag;
    plmn_hold_next = plmn_hold;
    n0_valid = 1'b0;
    r0 = '0;
    r1 = '0;
    n1_valid = 1'b0;
    st = ST_OK;

    unique case (phase)
      PH_LEN: begin
        message_length_next = b;
        phase_next = PH_EXT;
      end
      PH_EXT: begin
        if (b == ExtMark) begin
          if (error_code_next == ST_OK) error_code_next = ST_EXTENDED;
          phase_next = PH_DONE;
        end else begin
          phase_next = PH_CNT_HI;
        end
      end
      PH_CNT_HI: begin
        ies_left_next = {b, 8'd0};
        phase_next = PH_CNT_LO;
      end
      PH_CNT_LO: begin
        ies_left_next = {ies_left[15:8], b};
        phase_next = ({ies_left[15:8], b} != 16'd0) ? PH_ID_HI : PH_DONE;
      end
      PH_ID_HI: begin
        ie_ident_next = {b, 8'd0};
        phase_next = PH_ID_LO;
      end
      PH_ID_LO: begin
        ie_ident_next = {ie_ident[15:8], b};
        phase_next = PH_CRIT;
      end
      PH_CRIT: begin
        if ((ie_ident == IeGlobal || ie_ident == IeTas) && b != 8'd0 &&
            error_code == ST_OK) error_code_next = ST_CRIT;
        phase_next = PH_IELEN;
      end
      PH_IELEN: begin
        ie_bytes_left_next = b;
        length_sum_next = length_sum + {8'd0, b} + 16'd4;
        if (ie_ident == IeGlobal) phase_next = G_HDR;
        else if (ie_ident == IeName) phase_next = N_HDR0;
        else if (ie_ident == IeTas) phase_next = T_COUNT;
        else phase_next = PH_SKIP;
        if (b == 8'd0) begin
          ies_left_next = ies_dec;
          phase_next = (ies_dec != 16'd0) ? PH_ID_HI : PH_DONE;
        end
      end
      PH_DONE: ;
      default: begin
        ie_bytes_left_next = bytes_dec;
        case (phase)
          G_HDR: begin
            if (b[7]) phase_next = PH_SKIP;
            else begin
              header_pos_next = '0;
              shift_acc_next = '0;
              phase_next = G_PLMN;
            end
          end
          G_PLMN: begin
            shift_acc_next = shifted;
            header_pos_next = pos_inc;
            if (pos_inc == 4'd3) phase_next = G_TYPE;
          end
          G_TYPE: begin
            plmn_hold_next = shift_acc[23:0];
            home_flag_next = b[6];
            header_pos_next = '0;
            shift_acc_next = '0;
            phase_next = G_ID;
          end
          G_ID: begin
            shift_acc_next = shifted;
            header_pos_next = pos_inc;
            if (pos_inc == (home_flag ? 4'd4 : 4'd3)) begin
              n0_valid = 1'b1;
              r0.kind = KIND_GLOBAL;
              r0.mcc_digits = mcc_of(plmn_hold);
              r0.mnc_digits = mnc_of(plmn_hold);
              r0.home_enb = home_flag;
              r0.enb_ident = shifted[31:4];
              phase_next = PH_SKIP;
            end
          end
          N_HDR0: begin
            if (b[7]) phase_next = PH_SKIP;
            else begin
              shift_acc_next = {24'd0, b};
              phase_next = N_HDR1;
            end
          end
          N_HDR1: begin
            name_left_next = {1'b0, shift_acc[6:0], b[7]} + 9'd1;
            phase_next = N_CHARS;
          end
          N_CHARS: begin
            n0_valid = 1'b1;
            r0.kind = KIND_NAME;
            r0.name_char = b;
            name_left_next = name_left - 9'd1;
            if (name_left == 9'd1) phase_next = PH_SKIP;
          end
          T_COUNT: begin
            if (count_plus > 9'(MaxTaItems)) begin
              if (error_code == ST_OK) error_code_next = ST_TOO_MANY;
              phase_next = PH_SKIP;
            end else begin
              tas_left_next = count_plus[4:0];
              ta_count_next = '0;
              header_pos_next = '0;
              shift_acc_next = '0;
              phase_next = T_ITEM;
            end
          end
          T_ITEM: begin
            shift_acc_next = shifted;
            header_pos_next = pos_inc;
            if (pos_inc == 4'd3) begin
              n0_valid = 1'b1;
              r0.kind = KIND_TAC;
              r0.tracking_code = shifted[21:6];
              r0.ta_index = ta_count;
              plmns_left_next = b[5:3];
              plmn_count_next = '0;
              header_pos_next = '0;
              shift_acc_next = '0;
              phase_next = T_PLMN;
            end
          end
          T_PLMN: begin
            shift_acc_next = shifted;
            header_pos_next = pos_inc;
            if (pos_inc == 4'd3) begin
              n0_valid = 1'b1;
              r0.kind = KIND_PLMN;
              r0.mcc_digits = mcc_of(shifted[23:0]);
              r0.mnc_digits = mnc_of(shifted[23:0]);
              r0.ta_index = ta_count;
              r0.plmn_index = plmn_count;
              header_pos_next = '0;
              shift_acc_next = '0;
              if (plmns_left == 3'd0) begin
                ta_count_next = ta_count + 4'd1;
                tas_left_next = tas_dec;
                phase_next = (tas_dec != 5'd0) ? T_ITEM : PH_SKIP;
              end else begin
                plmns_left_next = plmns_left - 3'd1;
                plmn_count_next = plmn_count + 3'd1;
              end
            end
          end
          default: ;
        endcase
        if (bytes_dec == 8'd0) begin
          ies_left_next = ies_dec;
          phase_next = (ies_dec != 16'd0) ? PH_ID_HI : PH_DONE;
        end
      end
    endcase

    if (last) begin
      if (error_code_next != ST_OK) st = error_code_next;
      else if (phase_next != PH_DONE) st = ST_TRUNCATED;
      else if (length_sum_next != {8'd0, message_length_next}) st = ST_LENGTH;
      else st = ST_OK;
      n1_valid = 1'b1;
      r1 = '0;
      r1.kind = KIND_END;
      r1.status = st;
      r1.last_result = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      phase <= PH_LEN;
      header_pos <= '0;
      ies_left <= '0;
      ie_ident <= '0;
      ie_bytes_left <= '0;
      length_sum <= '0;
      message_length <= '0;
      shift_acc <= '0;
      name_left <= '0;
      tas_left <= '0;
      plmns_left <= '0;
      ta_count <= '0;
      plmn_count <= '0;
      error_code <= '0;
      home_flag <= 1'b0;
      plmn_hold <= '0;
    end else if (step) begin
      phase <= phase_next;
      header_pos <= header_pos_next;
      ies_left <= ies_left_next;
      ie_ident <= ie_ident_next;
      ie_bytes_left <= ie_bytes_left_next;
      length_sum <= length_sum_next;
      message_length <= message_length_next;
      shift_acc <= shift_acc_next;
      name_left <= name_left_next;
      tas_left <= tas_left_next;
      plmns_left <= plmns_left_next;
      ta_count <= ta_count_next;
      plmn_count <= plmn_count_next;
      error_code <= error_code_next;
      home_flag <= home_flag_next;
      plmn_hold <= plmn_hold_next;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/s1ie_out_queue.sv =====
`default_nettype none
// four-entry result fifo; takes up to two results per cycle
module s1ie_out_queue import s1ie_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic push0,
  input wire result_t d0,
  input wire logic push1,
  input wire result_t d1,
  output logic room2,
  s1ie_result_if.source m
);
  result_t mem [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count, count_next;
  logic pop;
  logic [1:0] n_push;

  assign pop = m.valid && m.ready;
  assign m.valid = (count != 3'd0);
  assign m.data = mem[rd_ptr];
  assign n_push = {1'b0, push0} + {1'b0, push1};
  assign count_next = count + {1'b0, n_push} - {2'd0, pop};
  // room for two more once this cycle settles
  assign room2 = (count <= 3'd2);

  always_ff @(posedge clk) begin
    if (push0) mem[wr_ptr] <= d0;
    if (push1) mem[push0 ? wr_ptr + 2'd1 : wr_ptr] <= d1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count_next;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/s1_setup_request_ie_parser.sv =====
`default_nettype none
// S1 Setup Request IE parser
// in: one message byte per beat with last_byte on the final byte
// out: decoded results (global eNB id, name chars, TACs, broadcast PLMNs)
//   and one end-status beat with last_result set per message
// the input beat is registered, then decoded combinationally into a
// four-entry result fifo; a result passes the input register and the fifo
// before it appears; throughput: one byte per cycle while the fifo has room for two results;
// a final byte can push a decode result plus the status
// ready drops only when the receiver stalls and the fifo nears full,
// so no result is lost or repeated
// rst (synchronous) clears the parser to the start of a message and
// empties the fifo and input register
module s1_setup_request_ie_parser import s1ie_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  s1ie_item_if.sink in_item,
  s1ie_result_if.source out_result
);
  logic in_valid;
  item_t in_reg;
  logic room2;
  logic step;
  logic n0_valid, n1_valid;
  result_t r0, r1;

  // the input register advances only when the fifo can absorb its results
  assign step = in_valid && room2;
  assign in_item.ready = !in_valid || room2;

  always_ff @(posedge clk) begin
    if (rst) in_valid <= 1'b0;
    else if (in_item.ready) in_valid <= in_item.valid;
  end

  always_ff @(posedge clk) begin
    if (in_item.ready && in_item.valid) in_reg <= in_item.data;
  end

  s1ie_decoder u_dec (
    .clk(clk), .rst(rst), .step(step),
    .b(in_reg.data_byte), .last(in_reg.last_byte),
    .n0_valid(n0_valid), .r0(r0), .n1_valid(n1_valid), .r1(r1)
  );

  s1ie_out_queue u_q (
    .clk(clk), .rst(rst),
    .push0(step && n0_valid), .d0(r0),
    .push1(step && n1_valid), .d1(r1),
    .room2(room2), .m(out_result)
  );
endmodule
`default_nettype wire

// ===== dv/s1ie_checker.sv =====
module s1ie_checker import s1ie_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input item_t in_data,
  input wire logic out_valid,
  input wire logic out_ready,
  input result_t out_data,
  output int fail_count,
  output int pending,
  output int result_total,
  output int status_total
);
  timeunit 1ns;
  timeprecision 1ps;

  phase_t phase;
  logic [3:0] header_pos;
  logic [15:0] ies_left;
  logic [15:0] ie_ident;
  logic [7:0] ie_bytes_left;
  logic [15:0] length_sum;
  logic [7:0] message_length;
  logic [31:0] shift_acc;
  logic [8:0] name_left;
  logic [4:0] tas_left;
  logic [2:0] plmns_left;
  logic [3:0] ta_count;
  logic [2:0] plmn_count;
  logic [2:0] error_code;
  logic home_flag;
  logic [23:0] plmn_hold;

  result_t expected_results[$];

  task automatic clear_message();
    phase = PH_LEN;
    header_pos = '0;
    ies_left = '0;
    ie_ident = '0;
    ie_bytes_left = '0;
    length_sum = '0;
    message_length = '0;
    shift_acc = '0;
    name_left = '0;
    tas_left = '0;
    plmns_left = '0;
    ta_count = '0;
    plmn_count = '0;
    error_code = ST_OK;
    home_flag = 1'b0;
    plmn_hold = '0;
  endtask

  task automatic raise_error(input status_t code);
    if (error_code == ST_OK) error_code = code;
  endtask

  task automatic close_ie();
    ies_left = ies_left - 16'd1;
    phase = (ies_left != 0) ? PH_ID_HI : PH_DONE;
  endtask

  function automatic result_t blank_result(input kind_t k);
    result_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

  // mcc = p0 low, p0 high, p1 low; mnc = p2 low, p2 high, p1 high
  function automatic result_t with_plmn(input result_t r, input logic [23:0] p);
    result_t t;
    t = r;
    t.mcc_digits = {p[19:16], p[23:20], p[11:8]};
    t.mnc_digits = {p[3:0], p[7:4], p[15:12]};
    return t;
  endfunction

  task automatic decode_value(input logic [7:0] b);
    result_t r;
    case (phase)
      G_HDR: begin
        if (b[7]) phase = PH_SKIP;
        else begin
          header_pos = 0;
          shift_acc = 0;
          phase = G_PLMN;
        end
      end
      G_PLMN: begin
        shift_acc = {shift_acc[23:0], b};
        header_pos++;
        if (header_pos == 3) phase = G_TYPE;
      end
      G_TYPE: begin
        plmn_hold = shift_acc[23:0];
        home_flag = b[6];
        header_pos = 0;
        shift_acc = 0;
        phase = G_ID;
      end
      G_ID: begin
        shift_acc = {shift_acc[23:0], b};
        header_pos++;
        if (header_pos == (home_flag ? 4 : 3)) begin
          r = with_plmn(blank_result(KIND_GLOBAL), plmn_hold);
          r.home_enb = home_flag;
          r.enb_ident = shift_acc[31:4];
          expected_results.push_back(r);
          phase = PH_SKIP;
        end
      end
      N_HDR0: begin
        if (b[7]) phase = PH_SKIP;
        else begin
          shift_acc = {24'd0, b};
          phase = N_HDR1;
        end
      end
      N_HDR1: begin
        name_left = {1'b0, shift_acc[6:0], 1'b0} + b[7] + 9'd1;
        phase = N_CHARS;
      end
      N_CHARS: begin
        r = blank_result(KIND_NAME);
        r.name_char = b;
        expected_results.push_back(r);
        name_left--;
        if (name_left == 0) phase = PH_SKIP;
      end
      T_COUNT: begin
        if (int'(b) + 1 > MaxTaItems) begin
          raise_error(ST_TOO_MANY);
          phase = PH_SKIP;
        end else begin
          tas_left = b[4:0] + 5'd1;
          ta_count = 0;
          header_pos = 0;
          shift_acc = 0;
          phase = T_ITEM;
        end
      end
      T_ITEM: begin
        shift_acc = {shift_acc[23:0], b};
        header_pos++;
        if (header_pos == 3) begin
          r = blank_result(KIND_TAC);
          r.tracking_code = shift_acc[21:6];
          r.ta_index = ta_count;
          expected_results.push_back(r);
          plmns_left = b[5:3];
          plmn_count = 0;
          header_pos = 0;
          shift_acc = 0;
          phase = T_PLMN;
        end
      end
      T_PLMN: begin
        shift_acc = {shift_acc[23:0], b};
        header_pos++;
        if (header_pos == 3) begin
          r = with_plmn(blank_result(KIND_PLMN), shift_acc[23:0]);
          r.ta_index = ta_count;
          r.plmn_index = plmn_count;
          expected_results.push_back(r);
          header_pos = 0;
          shift_acc = 0;
          if (plmns_left == 0) begin
            ta_count++;
            tas_left--;
            phase = (tas_left != 0) ? T_ITEM : PH_SKIP;
          end else begin
            plmns_left--;
            plmn_count++;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic last);
    result_t r;
    case (phase)
      PH_LEN: begin
        message_length = b;
        phase = PH_EXT;
      end
      PH_EXT: begin
        if (b == ExtMark) begin
          raise_error(ST_EXTENDED);
          phase = PH_DONE;
        end else phase = PH_CNT_HI;
      end
      PH_CNT_HI: begin
        ies_left = {b, 8'd0};
        phase = PH_CNT_LO;
      end
      PH_CNT_LO: begin
        ies_left[7:0] = b;
        phase = (ies_left != 0) ? PH_ID_HI : PH_DONE;
      end
      PH_ID_HI: begin
        ie_ident = {b, 8'd0};
        phase = PH_ID_LO;
      end
      PH_ID_LO: begin
        ie_ident[7:0] = b;
        phase = PH_CRIT;
      end
      PH_CRIT: begin
        if ((ie_ident == IeGlobal || ie_ident == IeTas) && b != 0) raise_error(ST_CRIT);
        phase = PH_IELEN;
      end
      PH_IELEN: begin
        ie_bytes_left = b;
        length_sum = length_sum + b + 16'd4;
        if (ie_ident == IeGlobal) phase = G_HDR;
        else if (ie_ident == IeName) phase = N_HDR0;
        else if (ie_ident == IeTas) phase = T_COUNT;
        else phase = PH_SKIP;
        if (b == 0) close_ie();
      end
      PH_DONE: ;
      default: begin
        ie_bytes_left--;
        decode_value(b);
        if (ie_bytes_left == 0) close_ie();
      end
    endcase
    if (last) begin
      r = blank_result(KIND_END);
      if (error_code != ST_OK) r.status = error_code;
      else if (phase != PH_DONE) r.status = ST_TRUNCATED;
      else if (length_sum != {8'd0, message_length}) r.status = ST_LENGTH;
      else r.status = ST_OK;
      r.last_result = 1'b1;
      expected_results.push_back(r);
      clear_message();
    end
  endtask

  task automatic compare_result(input result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      $error("result with nothing expected: %h", got);
      fail_count++;
      return;
    end
    want = expected_results.pop_front();
    if (got.kind != want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, got.kind); fail_count++;
    end
    if (got.mcc_digits != want.mcc_digits) begin
      $error("mcc_digits: expected %h, got %h", want.mcc_digits, got.mcc_digits);
      fail_count++;
    end
    if (got.mnc_digits != want.mnc_digits) begin
      $error("mnc_digits: expected %h, got %h", want.mnc_digits, got.mnc_digits);
      fail_count++;
    end
    if (got.home_enb != want.home_enb) begin
      $error("home_enb: expected %0d, got %0d", want.home_enb, got.home_enb);
      fail_count++;
    end
    if (got.enb_ident != want.enb_ident) begin
      $error("enb_ident: expected %h, got %h", want.enb_ident, got.enb_ident);
      fail_count++;
    end
    if (got.name_char != want.name_char) begin
      $error("name_char: expected %h, got %h", want.name_char, got.name_char);
      fail_count++;
    end
    if (got.tracking_code != want.tracking_code) begin
      $error("tracking_code: expected %h, got %h", want.tracking_code,
             got.tracking_code);
      fail_count++;
    end
    if (got.ta_index != want.ta_index) begin
      $error("ta_index: expected %0d, got %0d", want.ta_index, got.ta_index);
      fail_count++;
    end
    if (got.plmn_index != want.plmn_index) begin
      $error("plmn_index: expected %0d, got %0d", want.plmn_index, got.plmn_index);
      fail_count++;
    end
    if (got.status != want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      fail_count++;
    end
    if (got.last_result != want.last_result) begin
      $error("last_result: expected %0d, got %0d", want.last_result,
             got.last_result);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    result_total = 0;
    status_total = 0;
    clear_message();
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_message();
      expected_results.delete();
    end else begin
      // predict before comparing so a same-edge result could never be missed
      if (in_valid && in_ready) parse_byte(in_data.data_byte, in_data.last_byte);
      if (out_valid && out_ready) begin
        result_total++;
        if (out_data.last_result) status_total++;
        compare_result(out_data);
      end
    end
    pending = expected_results.size();
  end
endmodule

// ===== dv/testbench.sv =====
module testbench;
  import s1ie_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int fail_count;
  int pending;
  int result_total;
  int status_total;
  int idle_pct = 17;

  byte unsigned msg_bytes[$];
  int item_total = 0;
  int message_total = 0;

  s1ie_item_if in_item();
  s1ie_result_if out_result();

  s1_setup_request_ie_parser dut (
    .clk(clk),
    .rst(rst),
    .in_item(in_item.sink),
    .out_result(out_result.source)
  );

  s1ie_checker checker_inst (
    .clk(clk),
    .rst(rst),
    .in_valid(in_item.valid),
    .in_ready(in_item.ready),
    .in_data(in_item.data),
    .out_valid(out_result.valid),
    .out_ready(out_result.ready),
    .out_data(out_result.data),
    .fail_count(fail_count),
    .pending(pending),
    .result_total(result_total),
    .status_total(status_total)
  );

  always #10 clk = ~clk;

  initial begin
    in_item.valid = 1'b0;
    in_item.data = '0;
    out_result.ready = 1'b0;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    if (rst) out_result.ready <= 1'b0;
    else out_result.ready <= ($urandom_range(99) >= idle_pct);
  end

  task automatic send_byte(input byte unsigned b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_item.valid <= 1'b0;
      @(posedge clk);
    end
    in_item.valid <= 1'b1;
    in_item.data <= '{data_byte: b, last_byte: last};
    @(posedge clk);
    while (!in_item.ready) @(posedge clk);
    item_total++;
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_bytes.size(); i++)
      send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    msg_bytes.delete();
    message_total++;
  endtask

  task automatic add_ie(input int id, input byte unsigned crit,
                        input byte unsigned val[$]);
    msg_bytes.push_back(id[15:8]);
    msg_bytes.push_back(id[7:0]);
    msg_bytes.push_back(crit);
    msg_bytes.push_back(8'(val.size()));
    foreach (val[i]) msg_bytes.push_back(val[i]);
  endtask

  function automatic byte unsigned rnd_byte();
    return 8'($urandom_range(255));
  endfunction

  // well-formed message with random content; bad_kind injects one flaw
  task automatic build_message(input int bad_kind);
    byte unsigned v[$];
    int n_ies;
    int total;
    int ntas;
    int id;
    n_ies = $urandom_range(1, 3);
    total = 0;
    msg_bytes.push_back(0);
    msg_bytes.push_back((bad_kind == 4) ? ExtMark : 8'd0);
    msg_bytes.push_back(0);
    msg_bytes.push_back(8'(n_ies));
    for (int k = 0; k < n_ies; k++) begin
      v.delete();
      case ($urandom_range(3))
        0: begin
          id = IeGlobal;
          v.push_back($urandom_range(9) == 0 ? 8'h80 : 8'h00);
          repeat (3) v.push_back(rnd_byte());
          v.push_back(rnd_byte());
          repeat (4) v.push_back(rnd_byte());
        end
        1: begin
          id = IeName;
          v.push_back($urandom_range(9) == 0 ? 8'h80 : 8'($urandom_range(3)));
          v.push_back(rnd_byte());
          repeat ($urandom_range(2, 9)) v.push_back(rnd_byte());
        end
        2: begin
          id = IeTas;
          ntas = $urandom_range(1, 3);
          v.push_back((bad_kind == 3) ? 8'($urandom_range(16, 255)) : 8'(ntas - 1));
          repeat (ntas) begin
            byte unsigned third;
            int nb;
            nb = $urandom_range(0, 2);
            third = (rnd_byte() & 8'hc7) | 8'(nb << 3);
            v.push_back(rnd_byte());
            v.push_back(rnd_byte());
            v.push_back(third);
            repeat (3 * (nb + 1)) v.push_back(rnd_byte());
          end
        end
        default: begin
          id = ($urandom_range(1) != 0) ? 'h89 : $urandom_range(65535);
          repeat ($urandom_range(0, 4)) v.push_back(rnd_byte());
        end
      endcase
      // sometimes cut the IE short or pad it
      if ($urandom_range(7) == 0 && v.size() > 0) v = v[0:$urandom_range(v.size() - 1)];
      else if ($urandom_range(7) == 0) v.push_back(rnd_byte());
      add_ie(id, (bad_kind == 2) ? 8'($urandom_range(1, 255)) : 8'd0, v);
      total += v.size() + 4;
    end
    msg_bytes[0] = (bad_kind == 1) ? 8'(total + 1) : 8'(total);
    if (bad_kind == 5) msg_bytes = msg_bytes[0:$urandom_range(msg_bytes.size() - 2)];
    else if (bad_kind == 6) repeat ($urandom_range(1, 3)) msg_bytes.push_back(rnd_byte());
  endtask

  initial begin
    byte unsigned v[$];
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: home global id with all-ones bytes, macro id with zeros
    msg_bytes = '{8'd0, 8'd0, 8'd0, 8'd2};
    v = '{8'h00, 8'hff, 8'hff, 8'hff, 8'h40, 8'hff, 8'hff, 8'hff, 8'hff};
    add_ie(IeGlobal, 0, v);
    v = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    add_ie(IeGlobal, 8'hff, v);
    msg_bytes[0] = 8'd25;
    send_message();
    // name with length byte high bit, then ta count above max
    msg_bytes = '{8'd0, 8'd0, 8'd0, 8'd2};
    v = '{8'h00, 8'h80, 8'h41, 8'h7f};
    add_ie(IeName, 0, v);
    v = '{8'd16, 8'd0};
    add_ie(IeTas, 0, v);
    send_message();
    // extended message, zero ie count, single last byte
    msg_bytes = '{8'd0, ExtMark, 8'hff, 8'hff};
    send_message();
    msg_bytes = '{8'd0, 8'd0, 8'd0, 8'd0};
    send_message();
    msg_bytes = '{8'hff};
    send_message();
    // zero-length unknown ie
    msg_bytes = '{8'd4, 8'd1, 8'd0, 8'd1, 8'hff, 8'hff, 8'd0, 8'd0};
    send_message();

    while (item_total < 450) begin
      int r;
      r = $urandom_range(99);
      // long stretch without idling in the middle
      idle_pct = (item_total > 150 && item_total < 280) ? 0 : 17;
      if (r < 55) build_message(0);
      else if (r < 90) build_message($urandom_range(1, 6));
      else repeat ($urandom_range(1, 12)) msg_bytes.push_back(rnd_byte());
      send_message();
    end
    in_item.valid <= 1'b0;
    idle_pct = 17;

    // let the checker see the final beat before draining
    @(posedge clk);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("sent %0d bytes in %0d messages; checked %0d results, %0d of them status",
             item_total, message_total, result_total, status_total);
    if (fail_count == 0 && pending == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

  initial begin
    #2ms;
    $display("testbench NOT OK");
    $finish;
  end
endmodule
